### hw/rtl/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache classifier.
`default_nettype none

package salc_pkg;

  // Default geometry.
  localparam int unsigned NUM_SETS_DEF     = 512;
  localparam int unsigned NUM_WAYS_DEF     = 4;
  localparam int unsigned TAG_WIDTH_DEF    = 3;
  localparam int unsigned OFFSET_WIDTH_DEF = 4;

  // Fixed port widths.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned OUTCOME_W  = 2;
  localparam int unsigned WAY_OUT_W  = 2;
  // Widest rank over the supported way counts (up to 8 ways).
  localparam int unsigned RANK_MAX_W = 3;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT        = 2'd0,
    OUT_COMPULSORY = 2'd1,
    OUT_REPLACE    = 2'd2
  } outcome_e;

  // Status of the shared way compare unit for the way under test.
  typedef struct packed {
    logic                  empty;  // way is beyond the valid prefix
    logic                  match;  // stored tag equals lookup tag
    logic                  older;  // rank above the running maximum
    logic [RANK_MAX_W-1:0] rank;   // rank of the way, zero-extended
  } cmp_res_t;

endpackage

`default_nettype wire

### hw/rtl/salc_set_ram.sv
// Single-port-write, single-port-read set memory with registered read data.
`default_nettype none

module salc_set_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 9
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/salc_way_cmp.sv
// Shared way compare unit: selects one way of the set word and tests it.
`default_nettype none

module salc_way_cmp #(
  parameter int unsigned NUM_WAYS  = 4,
  parameter int unsigned TAG_WIDTH = 3,
  parameter int unsigned RW        = 2,
  parameter int unsigned WAY_W     = 2,
  parameter int unsigned FW        = 3
) (
  input  wire logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] tags_i,
  input  wire logic [NUM_WAYS-1:0][RW-1:0]        ranks_i,
  input  wire logic [FW-1:0]                      fill_i,
  input  wire logic [WAY_W-1:0]                   way_i,
  input  wire logic [TAG_WIDTH-1:0]               tag_i,
  input  wire logic [RW-1:0]                      max_rank_i,
  output salc_pkg::cmp_res_t                      res_o
);

  logic [RW-1:0] rank;

  assign rank = ranks_i[way_i];

  always_comb begin
    res_o       = '0;
    res_o.empty = (FW'(way_i) >= fill_i);
    res_o.match = (tags_i[way_i] == tag_i);
    res_o.older = (rank > max_rank_i);
    res_o.rank  = salc_pkg::RANK_MAX_W'(rank);
  end

endmodule

`default_nettype wire

### hw/rtl/set_assoc_cache_lru_classifier_top.sv
// Top level of the set-associative cache classifier with true LRU ranks.
//
//  channel | dir | handshake                  | word
//  --------+-----+----------------------------+-------------------------
//  in      | in  | in_valid_i / in_ready_o    | address_i[15:0]
//  out     | out | out_valid_o / out_ready_i  | outcome_o[1:0], way_used_o[1:0]
//
// An access scans from 1 up to NUM_WAYS ways, one at a time, through the
// shared compare unit, then writes the set word back to the memory; the next
// address is taken only after that write-back.
// After reset the block sweeps the set memory, one set per cycle, clearing
// fill counts; in_ready_o stays low during the sweep.
// The result sits in an output register; a stalled out channel holds the block
// only at write-back, so the next address is taken while a result waits.
`default_nettype none

module set_assoc_cache_lru_classifier_top #(
  parameter int unsigned NUM_SETS     = salc_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS     = salc_pkg::NUM_WAYS_DEF,
  parameter int unsigned TAG_WIDTH    = salc_pkg::TAG_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = salc_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [salc_pkg::ADDR_W-1:0]    address_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [salc_pkg::OUTCOME_W-1:0] outcome_o,
  output logic      [salc_pkg::WAY_OUT_W-1:0] way_used_o
);

  // Geometry derived from the parameters.
  localparam int unsigned SET_BITS  = $clog2(NUM_SETS);
  localparam int unsigned SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned RW        = $clog2(NUM_WAYS);
  localparam int unsigned WAY_W     = RW;
  localparam int unsigned FW        = $clog2(NUM_WAYS + 1);
  localparam int unsigned TAG_SHIFT = OFFSET_WIDTH + SET_BITS;
  localparam int unsigned TAG_EXT_W = TAG_WIDTH + salc_pkg::ADDR_W;
  localparam int unsigned ENTRY_W   = FW + NUM_WAYS * (TAG_WIDTH + RW);

  localparam logic [SET_W-1:0] SET_MASK = SET_W'((64'd1 << SET_BITS) - 64'd1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic     [SET_W-1:0]        clr_idx_q, clr_idx_d;
  logic     [SET_W-1:0]        set_q, set_d;
  logic     [TAG_WIDTH-1:0]    tag_q, tag_d;
  logic     [WAY_W-1:0]        way_q, way_d;
  logic     [WAY_W-1:0]        sel_way_q, sel_way_d;
  logic     [RW-1:0]           sel_rank_q, sel_rank_d;
  salc_pkg::outcome_e          kind_q, kind_d;
  logic                        out_valid_q, out_valid_d;
  salc_pkg::outcome_e          out_outcome_q;
  logic     [WAY_W-1:0]        out_way_q;

  // Address split.
  logic [salc_pkg::ADDR_W-1:0] addr_sh;
  logic [SET_W-1:0]            set_raw;
  logic [SET_W-1:0]            set_idx;
  logic [TAG_WIDTH-1:0]        tag_in;

  // Set memory ports and the unpacked set word.
  logic                              mem_we;
  logic                              mem_re;
  logic [SET_W-1:0]                  mem_waddr;
  logic [ENTRY_W-1:0]                mem_wdata;
  logic [ENTRY_W-1:0]                mem_rdata;
  logic [NUM_WAYS-1:0][RW-1:0]        rd_ranks;
  logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] rd_tags;
  logic [FW-1:0]                      rd_fill;
  logic [NUM_WAYS-1:0][RW-1:0]        new_ranks;
  logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] new_tags;
  logic [FW-1:0]                      new_fill;

  salc_pkg::cmp_res_t cmp_res;
  logic               upd_fire;

  // Set index, folded once into range when NUM_SETS is not a power of two.
  always_comb begin
    addr_sh = address_i >> OFFSET_WIDTH;
    set_raw = SET_W'(addr_sh) & SET_MASK;
    if ({1'b0, set_raw} >= (SET_W + 1)'(NUM_SETS)) begin
      set_idx = set_raw - LAST_SET - SET_W'(1);
    end else begin
      set_idx = set_raw;
    end
    tag_in = TAG_WIDTH'(TAG_EXT_W'(address_i) >> TAG_SHIFT);
  end

  salc_set_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ENTRY_W),
    .AW    (SET_W)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (set_idx),
    .rdata_o (mem_rdata)
  );

  // Set word: ranks on top, then tags, fill count (valid prefix length) at the bottom.
  assign {rd_ranks, rd_tags, rd_fill} = mem_rdata;

  salc_way_cmp #(
    .NUM_WAYS  (NUM_WAYS),
    .TAG_WIDTH (TAG_WIDTH),
    .RW        (RW),
    .WAY_W     (WAY_W),
    .FW        (FW)
  ) u_way_cmp (
    .tags_i     (rd_tags),
    .ranks_i    (rd_ranks),
    .fill_i     (rd_fill),
    .way_i      (way_q),
    .tag_i      (tag_q),
    .max_rank_i (sel_rank_q),
    .res_o      (cmp_res)
  );

  // Rank and tag update of the set word; each way on its own.
  always_comb begin
    for (int k = 0; k < NUM_WAYS; k++) begin
      new_tags[k]  = rd_tags[k];
      new_ranks[k] = rd_ranks[k];
      if (WAY_W'(k) == sel_way_q) begin
        new_tags[k]  = tag_q;
        new_ranks[k] = '0;
      end else begin
        unique case (kind_q)
          salc_pkg::OUT_COMPULSORY: begin
            if (FW'(k) < rd_fill) begin
              new_ranks[k] = rd_ranks[k] + RW'(1);
            end
          end
          salc_pkg::OUT_HIT: begin
            if ((FW'(k) < rd_fill) && (rd_ranks[k] < sel_rank_q)) begin
              new_ranks[k] = rd_ranks[k] + RW'(1);
            end
          end
          salc_pkg::OUT_REPLACE: begin
            if (rd_ranks[k] < sel_rank_q) begin
              new_ranks[k] = rd_ranks[k] + RW'(1);
            end
          end
          default: begin
            new_ranks[k] = rd_ranks[k];
          end
        endcase
      end
    end
    if (kind_q == salc_pkg::OUT_COMPULSORY) begin
      new_fill = rd_fill + FW'(1);
    end else begin
      new_fill = rd_fill;
    end
  end

  assign upd_fire   = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    set_d       = set_q;
    tag_d       = tag_q;
    way_d       = way_q;
    sel_way_d   = sel_way_q;
    sel_rank_d  = sel_rank_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = {new_ranks, new_tags, new_fill};

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
        if (clr_idx_q == LAST_SET) begin
          state_d = S_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + SET_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mem_re  = 1'b1;
          set_d   = set_idx;
          tag_d   = tag_in;
          way_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // One way per cycle: first empty way fills, first tag match hits,
        // otherwise track the oldest way (lowest index wins a tie).
        priority if (cmp_res.empty) begin
          kind_d    = salc_pkg::OUT_COMPULSORY;
          sel_way_d = way_q;
          state_d   = S_UPDATE;
        end else if (cmp_res.match) begin
          kind_d     = salc_pkg::OUT_HIT;
          sel_way_d  = way_q;
          sel_rank_d = cmp_res.rank[RW-1:0];
          state_d    = S_UPDATE;
        end else begin
          if ((way_q == '0) || cmp_res.older) begin
            sel_way_d  = way_q;
            sel_rank_d = cmp_res.rank[RW-1:0];
          end
          if (way_q == LAST_WAY) begin
            kind_d  = salc_pkg::OUT_REPLACE;
            state_d = S_UPDATE;
          end else begin
            way_d = way_q + WAY_W'(1);
          end
        end
      end
      S_UPDATE: begin
        if (upd_fire) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q      <= set_d;
    tag_q      <= tag_d;
    way_q      <= way_d;
    sel_way_q  <= sel_way_d;
    sel_rank_q <= sel_rank_d;
    kind_q     <= kind_d;
    if (upd_fire) begin
      out_outcome_q <= kind_q;
      out_way_q     <= sel_way_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = out_outcome_q;
  assign way_used_o  = salc_pkg::WAY_OUT_W'(out_way_q);

`ifndef NO_ASSERTIONS
  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ({1'b0, set_idx} < (SET_W + 1)'(NUM_SETS)))
    else $error("set index out of range");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && (way_q == LAST_WAY)) |=> (state_q == S_UPDATE))
    else $error("scan ran past the last way");

  a_fill_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && (kind_q == salc_pkg::OUT_COMPULSORY)) |-> (FW'(sel_way_q) == rd_fill))
    else $error("compulsory fill not at the end of the valid prefix");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && (kind_q == salc_pkg::OUT_HIT)) |-> (FW'(sel_way_q) < rd_fill))
    else $error("hit on an invalid way");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |-> (new_fill <= FW'(NUM_WAYS)))
    else $error("fill count beyond way count");
`endif

endmodule

`default_nettype wire
